// File: rtl/trz_pkg.sv
// Shared types, constants and codes of the triangle rasterizer with depth buffer.
`default_nettype none
package trz_pkg;

    localparam int DEF_WIDTH  = 64;
    localparam int DEF_HEIGHT = 64;

    localparam logic [31:0] RESET_CLEAR_COLOR = 32'hff949494;
    localparam logic [23:0] RESET_CLEAR_DEPTH = 24'd2560000;
    localparam logic [12:0] COUNT_MAX         = 13'd8191;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] REG_CLEAR_COLOR = 2'd0;
    localparam logic [1:0] REG_CLEAR_DEPTH = 2'd1;

    // box coordinate, edge accumulator, edge step and area widths
    localparam int CW  = 10;
    localparam int EW  = 36;
    localparam int SW  = 22;
    localparam int ARW = 34;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] bx;
        logic signed [15:0] by_coord;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [23:0]        az;
        logic [23:0]        bz;
        logic [23:0]        cz;
        logic [31:0]        face_color;
        logic [11:0]        pixel_addr;
    } item_t;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic [23:0] pixel_depth;
        logic [12:0] written_count;
        logic        degenerate;
    } result_t;

    typedef struct packed {
        logic [1:0]          op;
        logic                degen;
        logic                empty;
        logic [CW-1:0]       x0;
        logic [CW-1:0]       x1;
        logic [CW-1:0]       y0;
        logic [CW-1:0]       y1;
        logic signed [EW-1:0] eab;
        logic signed [EW-1:0] ebc;
        logic signed [EW-1:0] eca;
        logic signed [SW-1:0] dxab;
        logic signed [SW-1:0] dxbc;
        logic signed [SW-1:0] dxca;
        logic signed [SW-1:0] dyab;
        logic signed [SW-1:0] dybc;
        logic signed [SW-1:0] dyca;
        logic [ARW-1:0]      area;
        logic [23:0]         az;
        logic [23:0]         bz;
        logic [23:0]         cz;
        logic [31:0]         color;
        logic [11:0]         addr;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage
`default_nettype wire

// File: rtl/trz_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module trz_ram #(
    parameter int DW    = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DW-1:0]            wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/trz_front.sv
// Front end: accepts items, sets up bounding box, area and edge start values.
`default_nettype none
module trz_front import trz_pkg::*; #(
    parameter int WIDTH  = DEF_WIDTH,
    parameter int HEIGHT = DEF_HEIGHT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_stall,
    input  wire item_t     item,
    input  wire logic      init_busy,
    output logic           push,
    output cmd_t           push_cmd,
    input  wire q_status_t qstat
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_BOX  = 3'd1;
    localparam logic [2:0] F_MUL  = 3'd2;
    localparam logic [2:0] F_SIGN = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    localparam logic signed [12:0] XLIM = 13'(WIDTH - 1);
    localparam logic signed [12:0] YLIM = 13'(HEIGHT - 1);

    logic [2:0]           state_reg, state_next;
    item_t                item_reg;
    logic [10:0]          xs_reg, ys_reg;
    logic [CW-1:0]        x1_reg, y1_reg;
    logic                 empty_reg;
    logic [3:0]           step_reg;
    logic signed [33:0]   prod_reg;
    logic signed [EW-1:0] sum_reg [4];
    cmd_t                 cmd_reg;

    logic accept;
    logic signed [15:0] xmin, xmax, ymin, ymax;
    logic signed [16:0] tx, ty;
    logic signed [11:0] fx, fy;
    logic signed [12:0] xe, ye;
    logic [10:0] xs, ys;
    logic signed [16:0] dbax, dbay, dcbx, dcby, dacx, dacy;
    logic signed [16:0] px0, py0, ma, mb;
    logic [3:0] sm1;
    logic neg;
    logic signed [SW-1:0] sdbax, sdbay, sdcbx, sdcby, sdacx, sdacy;

    assign item_stall = init_busy || (state_reg != F_IDLE);
    assign accept     = item_valid && !item_stall;
    assign push       = (state_reg == F_PUSH) && !qstat.full;
    assign push_cmd   = cmd_reg;

    always_comb
    begin
        xmin = item_reg.ax;
        if (item_reg.bx < xmin) xmin = item_reg.bx;
        if (item_reg.cx < xmin) xmin = item_reg.cx;
        xmax = item_reg.ax;
        if (item_reg.bx > xmax) xmax = item_reg.bx;
        if (item_reg.cx > xmax) xmax = item_reg.cx;
        ymin = item_reg.ay;
        if (item_reg.by_coord < ymin) ymin = item_reg.by_coord;
        if (item_reg.cy < ymin) ymin = item_reg.cy;
        ymax = item_reg.ay;
        if (item_reg.by_coord > ymax) ymax = item_reg.by_coord;
        if (item_reg.cy > ymax) ymax = item_reg.cy;
        fx = xmin[15:4];
        fy = ymin[15:4];
        tx = 17'(xmax) + 17'sd15;
        ty = 17'(ymax) + 17'sd15;
        xe = tx[16:4];
        ye = ty[16:4];
        if (xe > XLIM) xe = XLIM;
        if (ye > YLIM) ye = YLIM;
        xs = fx[11] ? 11'd0 : fx[10:0];
        ys = fy[11] ? 11'd0 : fy[10:0];
    end

    always_comb
    begin
        dbax = 17'(item_reg.bx) - 17'(item_reg.ax);
        dbay = 17'(item_reg.by_coord) - 17'(item_reg.ay);
        dcbx = 17'(item_reg.cx) - 17'(item_reg.bx);
        dcby = 17'(item_reg.cy) - 17'(item_reg.by_coord);
        dacx = 17'(item_reg.ax) - 17'(item_reg.cx);
        dacy = 17'(item_reg.ay) - 17'(item_reg.cy);
        px0  = $signed({2'b00, xs_reg, 4'b0000});
        py0  = $signed({2'b00, ys_reg, 4'b0000});
        ma = '0;
        mb = '0;
        case (step_reg)
            4'd0:
            begin
                ma = dbax;
                mb = 17'(item_reg.cy) - 17'(item_reg.ay);
            end
            4'd1:
            begin
                ma = dbay;
                mb = 17'(item_reg.cx) - 17'(item_reg.ax);
            end
            4'd2:
            begin
                ma = dbax;
                mb = py0 - 17'(item_reg.ay);
            end
            4'd3:
            begin
                ma = dbay;
                mb = px0 - 17'(item_reg.ax);
            end
            4'd4:
            begin
                ma = dcbx;
                mb = py0 - 17'(item_reg.by_coord);
            end
            4'd5:
            begin
                ma = dcby;
                mb = px0 - 17'(item_reg.bx);
            end
            4'd6:
            begin
                ma = dacx;
                mb = py0 - 17'(item_reg.cy);
            end
            4'd7:
            begin
                ma = dacy;
                mb = px0 - 17'(item_reg.cx);
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
        sm1 = step_reg - 4'd1;
        neg = sum_reg[0][EW-1];
        sdbax = 22'(dbax) <<< 4;
        sdbay = 22'(dbay) <<< 4;
        sdcbx = 22'(dcbx) <<< 4;
        sdcby = 22'(dcby) <<< 4;
        sdacx = 22'(dacx) <<< 4;
        sdacy = 22'(dacy) <<< 4;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = (item.op == OP_DRAW) ? F_BOX : F_PUSH;
                end
            end
            F_BOX:  state_next = F_MUL;
            F_MUL:  state_next = (step_reg == 4'd8) ? F_SIGN : F_MUL;
            F_SIGN: state_next = F_PUSH;
            F_PUSH: state_next = push ? F_IDLE : F_PUSH;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    item_reg       <= item;
                    cmd_reg.op     <= item.op;
                    cmd_reg.addr   <= item.pixel_addr;
                    cmd_reg.degen  <= 1'b0;
                    cmd_reg.empty  <= 1'b1;
                end
            end
            F_BOX:
            begin
                xs_reg    <= xs;
                ys_reg    <= ys;
                x1_reg    <= xe[CW-1:0];
                y1_reg    <= ye[CW-1:0];
                empty_reg <= (xe < $signed({2'b00, xs})) || (ye < $signed({2'b00, ys}));
                step_reg  <= 4'd0;
                for (int i = 0; i < 4; i++)
                begin
                    sum_reg[i] <= '0;
                end
            end
            F_MUL:
            begin
                prod_reg <= 34'(ma) * 34'(mb);
                if (step_reg != 4'd0)
                begin
                    if (sm1[0])
                        sum_reg[sm1[2:1]] <= sum_reg[sm1[2:1]] - EW'(prod_reg);
                    else
                        sum_reg[sm1[2:1]] <= sum_reg[sm1[2:1]] + EW'(prod_reg);
                end
                step_reg <= step_reg + 4'd1;
            end
            F_SIGN:
            begin
                cmd_reg.degen <= (sum_reg[0] == '0);
                cmd_reg.empty <= empty_reg;
                cmd_reg.x0    <= xs_reg[CW-1:0];
                cmd_reg.x1    <= x1_reg;
                cmd_reg.y0    <= ys_reg[CW-1:0];
                cmd_reg.y1    <= y1_reg;
                cmd_reg.area  <= ARW'(neg ? -sum_reg[0] : sum_reg[0]);
                cmd_reg.eab   <= neg ? -sum_reg[1] : sum_reg[1];
                cmd_reg.ebc   <= neg ? -sum_reg[2] : sum_reg[2];
                cmd_reg.eca   <= neg ? -sum_reg[3] : sum_reg[3];
                cmd_reg.dxab  <= neg ? sdbay : -sdbay;
                cmd_reg.dxbc  <= neg ? sdcby : -sdcby;
                cmd_reg.dxca  <= neg ? sdacy : -sdacy;
                cmd_reg.dyab  <= neg ? -sdbax : sdbax;
                cmd_reg.dybc  <= neg ? -sdcbx : sdcbx;
                cmd_reg.dyca  <= neg ? -sdacx : sdacx;
                cmd_reg.az    <= item_reg.az;
                cmd_reg.bz    <= item_reg.bz;
                cmd_reg.cz    <= item_reg.cz;
                cmd_reg.color <= item_reg.face_color;
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/trz_queue.sv
// Two-entry command queue between the setup front end and the pixel back end.
`default_nettype none
module trz_queue import trz_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t wdata,
    input  wire logic pop,
    output cmd_t      rdata,
    output q_status_t qstat
);

    cmd_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;

    assign rdata       = mem_reg[rptr_reg];
    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push) wptr_reg <= ~wptr_reg;
            if (pop)  rptr_reg <= ~rptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

// File: rtl/trz_back.sv
// Back end: clear sweep, pixel read and bounding box walk with depth test.
`default_nettype none
module trz_back import trz_pkg::*; #(
    parameter int WIDTH  = DEF_WIDTH,
    parameter int HEIGHT = DEF_HEIGHT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd_q,
    input  wire q_status_t   qstat,
    output logic             pop,
    input  wire logic [31:0] clear_color,
    input  wire logic [23:0] clear_depth,
    output logic             init_busy,
    output logic             result_valid,
    input  wire logic        result_stall,
    output result_t          result
);

    localparam int NPIX = WIDTH * HEIGHT;
    localparam int AW   = $clog2(NPIX);

    localparam logic [3:0] B_INIT   = 4'd0;
    localparam logic [3:0] B_IDLE   = 4'd1;
    localparam logic [3:0] B_CLEAR  = 4'd2;
    localparam logic [3:0] B_RDWAIT = 4'd3;
    localparam logic [3:0] B_PIX    = 4'd4;
    localparam logic [3:0] B_MUL    = 4'd5;
    localparam logic [3:0] B_DIV    = 4'd6;
    localparam logic [3:0] B_CMP    = 4'd7;

    logic [3:0]           state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [AW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        x_reg, x_next, y_reg, y_next;
    logic signed [EW-1:0] e_reg [3];
    logic signed [EW-1:0] e_next [3];
    logic signed [EW-1:0] row_reg [3];
    logic signed [EW-1:0] row_next [3];
    logic [1:0]           mstep_reg, mstep_next;
    logic [57:0]          prod_reg, prod_next;
    logic [59:0]          num_reg, num_next;
    logic [35:0]          rem_reg, rem_next;
    logic [23:0]          dlow_reg, dlow_next;
    logic [23:0]          q_reg, q_next;
    logic [4:0]           dstep_reg, dstep_next;
    logic [12:0]          count_reg, count_next;
    logic                 res_valid_reg, res_valid_next;
    result_t              res_reg, res_next;

    logic          we, re;
    logic [AW-1:0] waddr, raddr, pix_idx;
    logic [31:0]   wcolor, rcolor;
    logic [23:0]   wdepth, rdepth;
    logic          in_tri, last, zlt, ge, in_range;
    logic signed [EW-1:0] dx_a [3];
    logic signed [EW-1:0] dy_a [3];
    logic [ARW-1:0] ma;
    logic [23:0]    mz;
    logic [59:0]    nsum;
    logic [35:0]    trial;

    trz_ram #(.DW(32), .DEPTH(NPIX)) u_color (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wcolor),
        .re(re), .raddr(raddr), .rdata(rcolor)
    );

    trz_ram #(.DW(24), .DEPTH(NPIX)) u_depth (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdepth),
        .re(re), .raddr(raddr), .rdata(rdepth)
    );

    assign init_busy    = (state_reg == B_INIT);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign pop          = (state_reg == B_IDLE) && !qstat.empty && !res_valid_reg;
    assign pix_idx      = AW'(32'(y_reg) * WIDTH + 32'(x_reg));
    assign in_range     = 32'(cmd_q.addr) < NPIX;

    always_comb
    begin
        dx_a[0] = EW'(cmd_reg.dxab);
        dx_a[1] = EW'(cmd_reg.dxbc);
        dx_a[2] = EW'(cmd_reg.dxca);
        dy_a[0] = EW'(cmd_reg.dyab);
        dy_a[1] = EW'(cmd_reg.dybc);
        dy_a[2] = EW'(cmd_reg.dyca);
        in_tri = !e_reg[0][EW-1] && !e_reg[1][EW-1] && !e_reg[2][EW-1];
        last   = (x_reg == cmd_reg.x1) && (y_reg == cmd_reg.y1);
        zlt    = q_reg < rdepth;
        case (mstep_reg)
            2'd0:
            begin
                ma = e_reg[1][ARW-1:0];
                mz = cmd_reg.az;
            end
            2'd1:
            begin
                ma = e_reg[2][ARW-1:0];
                mz = cmd_reg.bz;
            end
            2'd2:
            begin
                ma = e_reg[0][ARW-1:0];
                mz = cmd_reg.cz;
            end
            default:
            begin
                ma = '0;
                mz = '0;
            end
        endcase
        nsum  = num_reg + 60'(prod_reg);
        trial = {rem_reg[34:0], dlow_reg[23]};
        ge    = trial >= 36'(cmd_reg.area);
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        e_next         = e_reg;
        row_next       = row_reg;
        mstep_next     = mstep_reg;
        prod_next      = prod_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        dlow_next      = dlow_reg;
        q_next         = q_reg;
        dstep_next     = dstep_reg;
        count_next     = count_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_next       = res_reg;
        we     = 1'b0;
        re     = 1'b0;
        waddr  = cnt_reg;
        raddr  = pix_idx;
        wcolor = clear_color;
        wdepth = clear_depth;

        case (state_reg)
            B_INIT:
            begin
                we     = 1'b1;
                wcolor = RESET_CLEAR_COLOR;
                wdepth = RESET_CLEAR_DEPTH;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(NPIX - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (pop)
                begin
                    cmd_next = cmd_q;
                    res_next = '0;
                    cnt_next = '0;
                    case (cmd_q.op)
                        OP_CLEAR: state_next = B_CLEAR;
                        OP_READ:
                        begin
                            if (in_range)
                            begin
                                re         = 1'b1;
                                raddr      = AW'(cmd_q.addr);
                                state_next = B_RDWAIT;
                            end
                            else
                            begin
                                res_valid_next = 1'b1;
                            end
                        end
                        OP_DRAW:
                        begin
                            if (cmd_q.degen)
                            begin
                                res_next.degenerate = 1'b1;
                                res_valid_next      = 1'b1;
                            end
                            else if (cmd_q.empty)
                            begin
                                res_valid_next = 1'b1;
                            end
                            else
                            begin
                                x_next      = cmd_q.x0;
                                y_next      = cmd_q.y0;
                                e_next[0]   = cmd_q.eab;
                                e_next[1]   = cmd_q.ebc;
                                e_next[2]   = cmd_q.eca;
                                row_next[0] = cmd_q.eab;
                                row_next[1] = cmd_q.ebc;
                                row_next[2] = cmd_q.eca;
                                count_next  = '0;
                                state_next  = B_PIX;
                            end
                        end
                        default: res_valid_next = 1'b1;
                    endcase
                end
            end
            B_CLEAR:
            begin
                we       = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(NPIX - 1))
                begin
                    res_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            B_RDWAIT:
            begin
                res_next.pixel_color = rcolor;
                res_next.pixel_depth = rdepth;
                res_valid_next       = 1'b1;
                state_next           = B_IDLE;
            end
            B_PIX, B_CMP:
            begin
                if ((state_reg == B_PIX) && in_tri)
                begin
                    re         = 1'b1;
                    mstep_next = 2'd0;
                    num_next   = 60'(cmd_reg.area >> 1);
                    state_next = B_MUL;
                end
                else
                begin
                    if ((state_reg == B_CMP) && zlt)
                    begin
                        we     = 1'b1;
                        waddr  = pix_idx;
                        wcolor = cmd_reg.color;
                        wdepth = q_reg;
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + 13'd1;
                        end
                    end
                    state_next = B_PIX;
                    if (last)
                    begin
                        res_next.written_count = count_next;
                        res_valid_next         = 1'b1;
                        state_next             = B_IDLE;
                    end
                    else if (x_reg == cmd_reg.x1)
                    begin
                        x_next = cmd_reg.x0;
                        y_next = y_reg + 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            row_next[i] = row_reg[i] + dy_a[i];
                            e_next[i]   = row_reg[i] + dy_a[i];
                        end
                    end
                    else
                    begin
                        x_next = x_reg + 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            e_next[i] = e_reg[i] + dx_a[i];
                        end
                    end
                end
            end
            B_MUL:
            begin
                prod_next  = 58'(ma) * 58'(mz);
                mstep_next = mstep_reg + 2'd1;
                if (mstep_reg != 2'd0)
                begin
                    num_next = nsum;
                end
                if (mstep_reg == 2'd3)
                begin
                    rem_next   = nsum[59:24];
                    dlow_next  = nsum[23:0];
                    dstep_next = '0;
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                rem_next   = ge ? trial - 36'(cmd_reg.area) : trial;
                q_next     = {q_reg[22:0], ge};
                dlow_next  = {dlow_reg[22:0], 1'b0};
                dstep_next = dstep_reg + 5'd1;
                if (dstep_reg == 5'd23)
                begin
                    state_next = B_CMP;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        e_reg     <= e_next;
        row_reg   <= row_next;
        mstep_reg <= mstep_next;
        prod_reg  <= prod_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        dlow_reg  <= dlow_next;
        q_reg     <= q_next;
        dstep_reg <= dstep_next;
        count_reg <= count_next;
        res_reg   <= res_next;
    end

endmodule
`default_nettype wire

// File: rtl/triangle_rasterizer_zbuffer.sv
// Read: one RAM read, then the result. Clear: one write per pixel over all WIDTH*HEIGHT pixels.
// Draw: setup in the front end and a pass through the queue, then a walk over the box pixels;
// a pixel inside the triangle adds 3 shared multiplies, a 24-step divider and one depth RMW.
// One item is in the pixel back end at a time; a 2-entry queue and the setup
// front end take further items meanwhile.
// After reset a clearing pass over all WIDTH*HEIGHT pixels holds item_stall high.
`default_nettype none
module triangle_rasterizer_zbuffer import trz_pkg::*; #(
    parameter int WIDTH  = DEF_WIDTH,
    parameter int HEIGHT = DEF_HEIGHT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire item_t       item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output result_t          result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [31:0] clear_color_reg;
    logic [23:0] clear_depth_reg;
    logic        init_busy, q_push, q_pop;
    cmd_t        push_cmd, head_cmd;
    q_status_t   qstat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_color_reg <= RESET_CLEAR_COLOR;
            clear_depth_reg <= RESET_CLEAR_DEPTH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CLEAR_COLOR: clear_color_reg <= cfg_data;
                REG_CLEAR_DEPTH: clear_depth_reg <= cfg_data[23:0];
                default:
                begin
                end
            endcase
        end
    end

    trz_front #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_front (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .init_busy(init_busy), .push(q_push), .push_cmd(push_cmd), .qstat(qstat)
    );

    trz_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .wdata(push_cmd), .pop(q_pop), .rdata(head_cmd), .qstat(qstat)
    );

    trz_back #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_q(head_cmd), .qstat(qstat), .pop(q_pop),
        .clear_color(clear_color_reg), .clear_depth(clear_depth_reg),
        .init_busy(init_busy),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    a_init_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> item_stall)
        else $error("item accepted during clearing pass");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !qstat.full)
        else $error("queue overflow");

    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !qstat.empty && !result_valid)
        else $error("pop from empty queue or over pending result");

    a_degen_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.degenerate |->
            result.written_count == 13'd0 && result.pixel_depth == 24'd0)
        else $error("degenerate result carries data");

endmodule
`default_nettype wire

// File: verif/triangle_rasterizer_zbuffer_tb.sv
// Self-checking testbench for triangle_rasterizer_zbuffer: predicted draws, clears and reads.
`default_nettype none

module triangle_rasterizer_zbuffer_tb import trz_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    class raster_scoreboard;
        localparam int W = 64;
        localparam int H = 64;

        logic [31:0] fb_color [W*H];
        logic [23:0] fb_depth [W*H];
        logic [31:0] clr_color;
        logic [23:0] clr_depth;
        result_t     expected_results[$];
        int          errors;
        int          n_draw, n_read, n_clear, n_degen, n_pixels;

        function new();
            clr_color = RESET_CLEAR_COLOR;
            clr_depth = RESET_CLEAR_DEPTH;
            fill_frame();
            errors = 0;
            n_draw = 0;
            n_read = 0;
            n_clear = 0;
            n_degen = 0;
            n_pixels = 0;
        endfunction

        function void fill_frame();
            for (int i = 0; i < W*H; i++)
            begin
                fb_color[i] = clr_color;
                fb_depth[i] = clr_depth;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            if (idx == REG_CLEAR_COLOR)
                clr_color = data;
            else if (idx == REG_CLEAR_DEPTH)
                clr_depth = data[23:0];
        endfunction

        static function longint edge_fn(longint px, longint py, longint qx, longint qy,
                                        longint rx, longint ry);
            return (qx - px) * (ry - py) - (qy - py) * (rx - px);
        endfunction

        static function int floor16(int v);
            return v >>> 4;
        endfunction

        function result_t rasterize(item_t it);
            result_t r;
            longint ax, ay, bx, by, cx, cy, area, sgn, px, py, eab, ebc, eca, num, z;
            int x0, x1, y0, y1, idx;
            int cnt;
            r = '0;
            ax = it.ax; ay = it.ay; bx = it.bx; by = it.by_coord; cx = it.cx; cy = it.cy;
            area = edge_fn(ax, ay, bx, by, cx, cy);
            if (area == 0)
            begin
                r.degenerate = 1'b1;
                n_degen++;
                return r;
            end
            sgn = (area < 0) ? -1 : 1;
            area = area * sgn;
            x0 = floor16(int'(ax < bx ? (ax < cx ? ax : cx) : (bx < cx ? bx : cx)));
            x1 = -floor16(-int'(ax > bx ? (ax > cx ? ax : cx) : (bx > cx ? bx : cx)));
            y0 = floor16(int'(ay < by ? (ay < cy ? ay : cy) : (by < cy ? by : cy)));
            y1 = -floor16(-int'(ay > by ? (ay > cy ? ay : cy) : (by > cy ? by : cy)));
            if (x0 < 0) x0 = 0;
            if (y0 < 0) y0 = 0;
            if (x1 > W-1) x1 = W-1;
            if (y1 > H-1) y1 = H-1;
            cnt = 0;
            for (int y = y0; y <= y1; y++)
            begin
                for (int x = x0; x <= x1; x++)
                begin
                    px = x * 16;
                    py = y * 16;
                    eab = sgn * edge_fn(ax, ay, bx, by, px, py);
                    ebc = sgn * edge_fn(bx, by, cx, cy, px, py);
                    eca = sgn * edge_fn(cx, cy, ax, ay, px, py);
                    if (eab >= 0 && ebc >= 0 && eca >= 0)
                    begin
                        num = ebc * longint'(it.az) + eca * longint'(it.bz)
                            + eab * longint'(it.cz);
                        z = ((num + area / 2) / area) & 64'hFFFFFF;
                        idx = y * W + x;
                        if (z < longint'(fb_depth[idx]))
                        begin
                            fb_depth[idx] = z[23:0];
                            fb_color[idx] = it.face_color;
                            if (cnt < 8191) cnt++;
                        end
                    end
                end
            end
            n_pixels += cnt;
            r.written_count = cnt[12:0];
            return r;
        endfunction

        function void note_item(item_t it);
            result_t r;
            r = '0;
            case (it.op)
                OP_CLEAR:
                begin
                    fill_frame();
                    n_clear++;
                end
                OP_READ:
                begin
                    if (int'(it.pixel_addr) < W*H)
                    begin
                        r.pixel_color = fb_color[it.pixel_addr];
                        r.pixel_depth = fb_depth[it.pixel_addr];
                    end
                    n_read++;
                end
                OP_DRAW:
                begin
                    r = rasterize(it);
                    n_draw++;
                end
                default: ;
            endcase
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void check_result(result_t act);
            result_t exp_r;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $realtime, act);
                errors++;
                return;
            end
            exp_r = expected_results.pop_front();
            if (act.pixel_color !== exp_r.pixel_color)
            begin
                $display("%0t: pixel_color expected %h actual %h", $realtime,
                         exp_r.pixel_color, act.pixel_color);
                errors++;
            end
            if (act.pixel_depth !== exp_r.pixel_depth)
            begin
                $display("%0t: pixel_depth expected %h actual %h", $realtime,
                         exp_r.pixel_depth, act.pixel_depth);
                errors++;
            end
            if (act.written_count !== exp_r.written_count)
            begin
                $display("%0t: written_count expected %0d actual %0d", $realtime,
                         exp_r.written_count, act.written_count);
                errors++;
            end
            if (act.degenerate !== exp_r.degenerate)
            begin
                $display("%0t: degenerate expected %b actual %b", $realtime,
                         exp_r.degenerate, act.degenerate);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    raster_scoreboard sb;
    bit no_gaps;
    bit hold_req;
    int hold_left;

    triangle_rasterizer_zbuffer uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("triangle_rasterizer_zbuffer regression: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: checks each result beat; random stalls (none when no_gaps is set), plus a long hold-off on request
    always
    begin
        @(posedge clk);
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
        if (hold_req && hold_left == 0)
        begin
            hold_left = 3000;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (no_gaps)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(0, 99) < 30);
    end

    task automatic send_item(item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        sb.note_item(it);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    function automatic item_t make_op(logic [1:0] op, int addr);
        item_t it;
        it = '0;
        it.op = op;
        it.pixel_addr = addr[11:0];
        return it;
    endfunction

    function automatic item_t make_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                       int az, int bz, int cz, logic [31:0] col);
        item_t it;
        it = '0;
        it.op = OP_DRAW;
        it.ax = ax[15:0]; it.ay = ay[15:0];
        it.bx = bx[15:0]; it.by_coord = by[15:0];
        it.cx = cx[15:0]; it.cy = cy[15:0];
        it.az = az[23:0]; it.bz = bz[23:0]; it.cz = cz[23:0];
        it.face_color = col;
        it.pixel_addr = 12'($urandom());
        return it;
    endfunction

    function automatic item_t rand_small_tri();
        int mx, my;
        item_t it;
        mx = $urandom_range(0, 1023) - 32;
        my = $urandom_range(0, 1023) - 32;
        it = make_tri(mx + $urandom_range(0, 96) - 48, my + $urandom_range(0, 96) - 48,
                      mx + $urandom_range(0, 96) - 48, my + $urandom_range(0, 96) - 48,
                      mx + $urandom_range(0, 96) - 48, my + $urandom_range(0, 96) - 48,
                      $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                      $urandom_range(0, 24'hFFFFFF), $urandom());
        if ($urandom_range(0, 9) == 0)
        begin
            it.cx = it.ax;
            it.cy = it.ay;
        end
        return it;
    endfunction

    // full-range coordinates, kept off the window so the walk stays cheap
    function automatic item_t rand_far_tri();
        item_t it;
        int lo_x, hi_x, lo_y, hi_y;
        do
        begin
            it = make_tri($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
            lo_x = it.ax < it.bx ? (it.ax < it.cx ? it.ax : it.cx) : (it.bx < it.cx ? it.bx : it.cx);
            hi_x = it.ax > it.bx ? (it.ax > it.cx ? it.ax : it.cx) : (it.bx > it.cx ? it.bx : it.cx);
            lo_y = it.ay < it.by_coord ? (it.ay < it.cy ? it.ay : it.cy)
                                       : (it.by_coord < it.cy ? it.by_coord : it.cy);
            hi_y = it.ay > it.by_coord ? (it.ay > it.cy ? it.ay : it.cy)
                                       : (it.by_coord > it.cy ? it.by_coord : it.cy);
        end
        while (!(lo_x > 1024 || hi_x < -16 || lo_y > 1024 || hi_y < -16));
        return it;
    endfunction

    function automatic item_t rand_item();
        int r;
        r = $urandom_range(0, 199);
        if (r < 80) return rand_small_tri();
        if (r < 90) return rand_far_tri();
        if (r < 180) return make_op(OP_READ, $urandom_range(0, 4095));
        if (r < 198) return make_op(OP_UNUSED, $urandom());
        return make_op(OP_CLEAR, 0);
    endfunction

    initial
    begin
        item_t it;
        sb = new();
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_CLEAR_COLOR;
        cfg_data = '0;
        no_gaps = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(make_op(OP_READ, 0));
        send_item(make_op(OP_READ, 4095));
        send_item(make_op(OP_UNUSED, 12'hFFF));
        send_item(make_tri(-32768, 0, 32767, 0, 0, 0, 0, 24'hFFFFFF, 5, 32'hFFFFFFFF));
        send_item(make_tri(30000, 30000, 30000, 30000, 30000, 30000, 1, 2, 3, 32'h1));
        send_item(make_tri(-800, -800, -400, -800, -800, -400, 7, 8, 9, 32'h2));
        send_item(make_tri(160, 160, 320, 160, 160, 320, 0, 24'hFFFFFF, 1000, 32'hA5A5A5A5));
        send_item(make_tri(400, 400, 400, 560, 560, 400, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                           32'h12345678));
        send_item(make_tri(400, 400, 400, 560, 560, 400, 500, 500, 500, 32'h11111111));
        send_item(make_tri(400, 400, 400, 560, 560, 400, 500, 500, 500, 32'h22222222));
        send_item(make_tri(-32768, -32768, 32767, -32768, -32768, 32767,
                           100, 200, 300, 32'h5A5A5A5A));
        send_item(make_op(OP_READ, 27 * 64 + 27));
        send_item(make_op(OP_READ, 63 * 64 + 63));
        send_item(make_op(OP_READ, 12 * 64 + 12));
        send_item(make_op(OP_CLEAR, 0));
        send_item(make_op(OP_READ, 100));
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_cfg(REG_CLEAR_COLOR, 32'h0);
                    write_cfg(REG_CLEAR_DEPTH, 32'h0);
                end
                1:
                begin
                    write_cfg(REG_CLEAR_COLOR, 32'hFFFFFFFF);
                    write_cfg(REG_CLEAR_DEPTH, 32'h00FFFFFF);
                end
                2:
                begin
                    write_cfg(REG_CLEAR_DEPTH, $urandom());
                    write_cfg(REG_CLEAR_COLOR, $urandom());
                end
                default:
                begin
                    write_cfg(REG_CLEAR_COLOR, RESET_CLEAR_COLOR);
                    write_cfg(REG_CLEAR_DEPTH, {8'h0, RESET_CLEAR_DEPTH});
                end
            endcase
            no_gaps = (phase == 2);
            send_item(make_op(OP_CLEAR, 0));
            for (int n = 0; n < 300; n++)
            begin
                if (phase == 1 && n == 40)
                    hold_req = 1'b1;
                if (phase == 3 && n == 150)
                    drain();
                it = rand_item();
                send_item(it);
            end
            drain();
        end

        $display("covered %0d draws (%0d zero-area, %0d pixels written), %0d reads, %0d clears",
                 sb.n_draw, sb.n_degen, sb.n_pixels, sb.n_read, sb.n_clear);
        $display("clear registers swept through zero, all-ones, random and reset values");
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("triangle_rasterizer_zbuffer regression: pass");
        else
            $display("triangle_rasterizer_zbuffer regression: fail");
        $finish;
    end
endmodule

`default_nettype wire

// File: files.f
rtl/trz_pkg.sv
rtl/trz_ram.sv
rtl/trz_front.sv
rtl/trz_queue.sv
rtl/trz_back.sv
rtl/triangle_rasterizer_zbuffer.sv
verif/triangle_rasterizer_zbuffer_tb.sv
